// ===== design/gain_scheduled_pi_clock_sync_defines.svh =====
// ---------------------------------------------------------------------------
// gain scheduled pi clock sync: assertion macros
// concurrent checks on the rising clock edge, held off during reset
// ---------------------------------------------------------------------------
`ifndef GAIN_SCHEDULED_PI_CLOCK_SYNC_DEFINES_SVH
`define GAIN_SCHEDULED_PI_CLOCK_SYNC_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold at every edge
`define GSPI_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("gspi assertion failed");
// antecedent implies consequent in the same cycle
`define GSPI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gspi assertion failed");
`else
`define GSPI_ASSERT(label, cond)
`define GSPI_ASSERT_IMPL(label, ante, cons)
`endif

`endif

// ===== design/gspi_pkg.sv =====
// ---------------------------------------------------------------------------
// gspi_pkg
// types and constants of the gain scheduled pi clock sync controller
// ---------------------------------------------------------------------------
package gspi_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_SYNC_INTERVAL  = 3'd0;
  localparam logic [2:0] REG_SAMPLES        = 3'd1;
  localparam logic [2:0] REG_SAMPLE_TICKS   = 3'd2;
  localparam logic [2:0] REG_KP_INIT        = 3'd3;
  localparam logic [2:0] REG_KI_INIT        = 3'd4;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd5;
  localparam logic [2:0] REG_DRIVE_LIMIT    = 3'd6;

  // gain schedule thresholds and smoothing constants on the smoothed absolute error
  localparam logic [29:0] STEP1_BELOW  = 30'd1000000;
  localparam logic [29:0] STEP2_BELOW  = 30'd200000;
  localparam logic [29:0] RESET_ABOVE  = 30'd2000000;
  localparam logic [29:0] SMOOTH_RESET = 30'd20000000;
  localparam logic [29:0] SMOOTH_MAX   = 30'h3FFFFFFF;
  localparam logic [23:0] SMOOTH_DIV   = 24'd5;

  // schedule steps
  localparam logic [1:0] STEP_INIT = 2'd0;
  localparam logic [1:0] STEP_ONE  = 2'd1;
  localparam logic [1:0] STEP_TWO  = 2'd2;

  // serial divider lengths (quotient bits per operation)
  localparam logic [5:0] LEN_SMOOTH = 6'd33;
  localparam logic [5:0] LEN_GAIN   = 6'd41;
  localparam logic [5:0] LEN_SPLIT  = 6'd24;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_FOLD,
    S_SLOAD,
    S_SMOOTH,
    S_SCHED,
    S_ILOAD,
    S_IDIV,
    S_ISUM,
    S_PDIV,
    S_DRIVE,
    S_DLOAD,
    S_SDIV,
    S_DONE
  } gspi_state_t;

endpackage

// ===== design/gain_scheduled_pi_clock_sync.sv =====
// ---------------------------------------------------------------------------
// gain scheduled pi clock sync
// pi phase controller with a three step gain schedule for clock alignment
// ---------------------------------------------------------------------------
// Each input item carries the remote and local clock positions inside one
// sync interval; the block folds their difference into a phase error, updates
// a smoothed absolute error and the gain schedule, runs a saturating pi law
// and splits the drive into a per-sample tick count and a remainder. A result
// reaches the output register once its item has passed the sequencing
// states and four divisions; no item is accepted before it gets there:
// every division goes through a single shared restoring divider that produces
// one quotient bit per cycle (33 bits for the smoothing, 41 bits each for the
// integral and proportional terms, 24 bits for the per-sample split), and
// the sequencing states include the idle state that takes the item.
// Items are processed one at a time; a finished result sits in the output
// register while the next item is accepted, and a result that is still
// stalled there holds the block and its input until it is taken.
// Configuration must be written only while no item is in flight; writing an
// initial inverse gain also loads the current gain of that term.
// ---------------------------------------------------------------------------
`include "gain_scheduled_pi_clock_sync_defines.svh"

module gain_scheduled_pi_clock_sync
  import gspi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [29:0]        remote_offset_ns,
  input  logic [29:0]        local_offset_ns,
  input  logic               local_offset_valid,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        ticks_per_sample,
  output logic [23:0]        remainder_ns,
  output logic signed [24:0] drive_ns,
  output logic [1:0]         gain_step
);

  // configuration registers
  logic [29:0] sync_len_ns;
  logic [19:0] sample_count;
  logic [31:0] base_ticks;
  logic [19:0] kp_inverse_init;
  logic [19:0] ki_inverse_init;
  logic [26:0] integral_limit;
  logic [23:0] drive_limit;

  // controller state
  logic signed [27:0] integral_sum;
  logic [29:0]        smoothed_abs_error;
  logic [1:0]         gain_schedule_step;
  logic [23:0]        kp_inverse_now;
  logic [23:0]        ki_inverse_now;

  // item working registers
  logic [29:0]        remote_r;
  logic [29:0]        local_r;
  logic               valid_r;
  logic signed [31:0] diff;
  logic signed [31:0] phase;
  logic signed [24:0] drive;

  // serial divider
  logic [40:0] dvd;     // dividend shifts out at the top, quotient in at the bottom
  logic [23:0] drem;    // partial remainder
  logic [23:0] dsor;
  logic [5:0]  dcnt;

  gspi_state_t state, state_next;

  // ---------------------------------------------------------------------
  // combinational datapath
  // ---------------------------------------------------------------------
  logic               accept;
  logic signed [31:0] diff_next;
  logic signed [31:0] half;
  logic signed [31:0] interval_s;
  logic signed [31:0] phase_next;
  logic signed [31:0] phase_abs;
  logic [30:0]        mag;
  logic               err_neg;
  logic [32:0]        smooth_num;
  logic [24:0]        div_shift;
  logic [25:0]        div_trial;
  logic               div_bit;
  logic [29:0]        sm_sat;
  logic signed [42:0] gain_term;
  logic signed [42:0] isum;
  logic signed [42:0] ilim;
  logic signed [42:0] dsum;
  logic signed [42:0] dlim;
  logic [23:0]        drive_mag;
  logic signed [31:0] per_sample;
  logic               div_last;
  logic               out_free;

  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign div_last   = (dcnt == 6'd1);

  assign diff_next  = $signed({2'b00, remote_r}) - $signed({2'b00, local_r});
  assign half       = $signed({3'b000, sync_len_ns[29:1]});
  assign interval_s = $signed({2'b00, sync_len_ns});

  // fold once into plus or minus half an interval
  always_comb begin
    if (!valid_r) begin
      phase_next = '0;
    end else if (diff < -half) begin
      phase_next = diff + interval_s;
    end else if (diff > half) begin
      phase_next = diff - interval_s;
    end else begin
      phase_next = diff;
    end
  end

  assign phase_abs  = phase[31] ? -phase : phase;
  assign mag        = phase_abs[30:0];
  // the error fed to the pi law is minus the phase
  assign err_neg    = !phase[31] && (phase != '0);
  assign smooth_num = {1'b0, smoothed_abs_error, 2'b00} + {2'b00, mag};

  // one restoring step
  assign div_shift  = {drem, dvd[40]};
  assign div_trial  = {1'b0, div_shift} - {2'b00, dsor};
  assign div_bit    = !div_trial[25];

  assign sm_sat     = (dvd[32:30] != 3'b000) ? SMOOTH_MAX : dvd[29:0];

  // signed gain term from the unsigned quotient
  assign gain_term  = err_neg ? -$signed({2'b00, dvd}) : $signed({2'b00, dvd});

  assign isum = $signed({{15{integral_sum[27]}}, integral_sum})
              + ((ki_inverse_now == '0) ? 43'sd0 : gain_term);
  assign ilim = $signed({16'b0, integral_limit});
  assign dsum = $signed({{15{integral_sum[27]}}, integral_sum})
              + ((kp_inverse_now == '0) ? 43'sd0 : gain_term);
  assign dlim = $signed({19'b0, drive_limit});

  assign drive_mag  = drive[24] ? 24'(-drive) : drive[23:0];
  assign per_sample = (sample_count == '0) ? 32'sd0 :
                      (drive[24] ? -$signed({7'b0, dvd[24:0]})
                                 :  $signed({7'b0, dvd[24:0]}));

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = S_DIFF;
      end
      S_DIFF:   state_next = S_FOLD;
      S_FOLD:   state_next = S_SLOAD;
      S_SLOAD:  state_next = S_SMOOTH;
      S_SMOOTH: if (div_last) state_next = S_SCHED;
      S_SCHED:  state_next = S_ILOAD;
      S_ILOAD:  state_next = S_IDIV;
      S_IDIV:   if (div_last) state_next = S_ISUM;
      S_ISUM:   state_next = S_PDIV;
      S_PDIV:   if (div_last) state_next = S_DRIVE;
      S_DRIVE:  state_next = S_DLOAD;
      S_DLOAD:  state_next = S_SDIV;
      S_SDIV:   if (div_last) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // configuration and controller state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_len_ns           <= 30'd100000000;
      sample_count          <= 20'd10000;
      base_ticks            <= 32'd2000;
      kp_inverse_init       <= 20'd930;
      ki_inverse_init       <= 20'd11377;
      integral_limit        <= 27'd10000000;
      drive_limit           <= 24'd200000;
      integral_sum          <= '0;
      smoothed_abs_error    <= SMOOTH_RESET;
      gain_schedule_step    <= STEP_INIT;
      kp_inverse_now        <= 24'd930;
      ki_inverse_now        <= 24'd11377;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC_INTERVAL:  sync_len_ns           <= cfg_data[29:0];
          REG_SAMPLES:        sample_count          <= cfg_data[19:0];
          REG_SAMPLE_TICKS:   base_ticks            <= cfg_data;
          REG_KP_INIT: begin
            kp_inverse_init <= cfg_data[19:0];
            kp_inverse_now  <= {4'b0, cfg_data[19:0]};
          end
          REG_KI_INIT: begin
            ki_inverse_init <= cfg_data[19:0];
            ki_inverse_now  <= {4'b0, cfg_data[19:0]};
          end
          REG_INTEGRAL_LIMIT: integral_limit        <= cfg_data[26:0];
          REG_DRIVE_LIMIT:    drive_limit           <= cfg_data[23:0];
          default: ;
        endcase
      end
      case (state)
        S_SCHED: begin
          smoothed_abs_error <= sm_sat;
          if (sm_sat < STEP1_BELOW && gain_schedule_step == STEP_INIT) begin
            kp_inverse_now     <= {kp_inverse_now[22:0], 1'b0};
            ki_inverse_now     <= {ki_inverse_now[22:0], 1'b0};
            gain_schedule_step <= STEP_ONE;
          end else if (sm_sat < STEP2_BELOW && gain_schedule_step == STEP_ONE) begin
            kp_inverse_now     <= {kp_inverse_now[22:0], 1'b0};
            ki_inverse_now     <= {ki_inverse_now[22:0], 1'b0};
            gain_schedule_step <= STEP_TWO;
          end else if (sm_sat > RESET_ABOVE && gain_schedule_step != STEP_INIT) begin
            kp_inverse_now     <= {4'b0, kp_inverse_init};
            ki_inverse_now     <= {4'b0, ki_inverse_init};
            gain_schedule_step <= STEP_INIT;
          end
        end
        S_ISUM: begin
          // saturate the integral at the sum limit
          if (isum > ilim) begin
            integral_sum <= 28'(ilim);
          end else if (isum < -ilim) begin
            integral_sum <= 28'(-ilim);
          end else begin
            integral_sum <= isum[27:0];
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // item datapath and serial divider
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      remote_r <= remote_offset_ns;
      local_r  <= local_offset_ns;
      valid_r  <= local_offset_valid;
    end
    case (state)
      S_DIFF: diff  <= diff_next;
      S_FOLD: phase <= phase_next;
      S_SLOAD: begin
        // (4 * smoothed + |phase|) / 5
        dvd  <= {smooth_num, 8'b0};
        drem <= '0;
        dsor <= SMOOTH_DIV;
        dcnt <= LEN_SMOOTH;
      end
      S_ILOAD: begin
        dvd  <= {mag, 10'b0};
        drem <= '0;
        dsor <= ki_inverse_now;
        dcnt <= LEN_GAIN;
      end
      S_ISUM: begin
        dvd  <= {mag, 10'b0};
        drem <= '0;
        dsor <= kp_inverse_now;
        dcnt <= LEN_GAIN;
      end
      S_DRIVE: begin
        // proportional term plus the new integral, saturated
        if (dsum > dlim) begin
          drive <= 25'(dlim);
        end else if (dsum < -dlim) begin
          drive <= 25'(-dlim);
        end else begin
          drive <= dsum[24:0];
        end
      end
      S_DLOAD: begin
        dvd  <= {drive_mag, 17'b0};
        drem <= '0;
        dsor <= {4'b0, sample_count};
        dcnt <= LEN_SPLIT;
      end
      S_SMOOTH, S_IDIV, S_PDIV, S_SDIV: begin
        dvd  <= {dvd[39:0], div_bit};
        drem <= div_bit ? div_trial[23:0] : div_shift[23:0];
        dcnt <= dcnt - 6'd1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      ticks_per_sample <= base_ticks - per_sample;
      remainder_ns     <= (sample_count == '0) ? drive_mag : drem;
      drive_ns         <= drive;
      gain_step        <= gain_schedule_step;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `GSPI_ASSERT_IMPL(a_step_init_gains, gain_schedule_step == STEP_INIT,
                    kp_inverse_now == {4'b0, kp_inverse_init} &&
                    ki_inverse_now == {4'b0, ki_inverse_init})
  `GSPI_ASSERT(a_step_range, gain_schedule_step != 2'd3)
  `GSPI_ASSERT_IMPL(a_drive_bound, out_valid,
                    (drive_ns <= $signed({1'b0, drive_limit})) &&
                    (drive_ns >= -$signed({1'b0, drive_limit})))
  `GSPI_ASSERT_IMPL(a_remainder_bound, out_valid && sample_count != '0,
                    remainder_ns < {4'b0, sample_count})
  `GSPI_ASSERT_IMPL(a_done_holds, state == S_DONE && !out_free,
                    state_next == S_DONE && in_stall)

endmodule

// ===== verif/tb_gain_scheduled_pi_clock_sync.sv =====
// ---------------------------------------------------------------------------
// tb_gain_scheduled_pi_clock_sync
// self-checking testbench of the gain scheduled pi clock sync controller
// ---------------------------------------------------------------------------
// A behavioral predictor computes the result of every accepted item: fold of
// the phase error, smoothing, gain schedule, saturating pi law and
// per-sample split. Results are checked in order, field by field. Both
// sides idle at random. The run covers directed corner items, register
// extremes and random configurations, and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_gain_scheduled_pi_clock_sync;
  import gspi_pkg::*;

  typedef struct packed {
    logic [31:0]        ticks;
    logic [23:0]        rem;
    logic signed [24:0] drive;
    logic [1:0]         step;
  } sync_result_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 2000;
  localparam int DRAIN_GAP  = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = REG_SYNC_INTERVAL;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [29:0]        remote_offset_ns = '0;
  logic [29:0]        local_offset_ns = '0;
  logic               local_offset_valid = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        ticks_per_sample;
  logic [23:0]        remainder_ns;
  logic signed [24:0] drive_ns;
  logic [1:0]         gain_step;

  gain_scheduled_pi_clock_sync u_top (.*);

  always #1 clk = ~clk;

  // predictor copy of the registers
  longint sync_ns, samples, nominal_ticks, kp_init, ki_init, integ_lim, drive_lim;
  // predictor copy of the controller state
  longint integ, smooth_err, kp_now, ki_now;
  logic [1:0] sched_step;

  sync_result_t pending_results[$];
  int fails = 0, items_sent = 0, results_seen = 0, cfg_writes = 0;
  bit no_idle = 0;          // stretches without random gaps
  int hold_trig = 0;        // bumped by a test to request a long hold-off

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // a zero or negative divisor yields zero
  function automatic longint div_or_zero(longint num, longint den);
    if (den <= 0) return 0;
    return num / den;
  endfunction

  function automatic void model_reset();
    sync_ns = 100000000; samples = 10000; nominal_ticks = 2000;
    kp_init = 930; ki_init = 11377; integ_lim = 10000000; drive_lim = 200000;
    integ = 0; smooth_err = SMOOTH_RESET; sched_step = STEP_INIT;
    kp_now = kp_init; ki_now = ki_init;
  endfunction

  function automatic sync_result_t pi_update(logic [29:0] rmt, logic [29:0] loc,
                                             logic vld);
    longint phase, mag, sm, err, drive, per, fpart, rem;
    sync_result_t r;
    phase = 0;
    if (vld) begin
      phase = longint'(rmt) - longint'(loc);
      // one fold only
      if (phase < -(sync_ns / 2)) phase += sync_ns;
      else if (phase > sync_ns / 2) phase -= sync_ns;
    end
    mag = phase < 0 ? -phase : phase;
    sm = (4 * smooth_err + mag) / 5;
    if (sm > longint'(SMOOTH_MAX)) sm = SMOOTH_MAX;
    smooth_err = sm;
    // gain schedule: tighten in two steps, fall back on large error
    if (sm < longint'(STEP1_BELOW) && sched_step == STEP_INIT) begin
      kp_now *= 2; ki_now *= 2; sched_step = STEP_ONE;
    end else if (sm < longint'(STEP2_BELOW) && sched_step == STEP_ONE) begin
      kp_now *= 2; ki_now *= 2; sched_step = STEP_TWO;
    end else if (sm > longint'(RESET_ABOVE) && sched_step != STEP_INIT) begin
      kp_now = kp_init; ki_now = ki_init; sched_step = STEP_INIT;
    end
    err = -phase;
    integ = clamp_sym(integ + div_or_zero(1024 * err, ki_now), integ_lim);
    drive = clamp_sym(div_or_zero(1024 * err, kp_now) + integ, drive_lim);
    per = div_or_zero(drive, samples);
    fpart = samples * per;
    rem = drive >= fpart ? drive - fpart : fpart - drive;
    r.ticks = 32'(nominal_ticks - per);
    r.rem = 24'(rem);
    r.drive = 25'(drive);
    r.step = sched_step;
    return r;
  endfunction

  function automatic void model_write(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_SYNC_INTERVAL:  sync_ns = val[29:0];
      REG_SAMPLES:        samples = val[19:0];
      REG_SAMPLE_TICKS:   nominal_ticks = val;
      REG_KP_INIT:        begin kp_init = val[19:0]; kp_now = kp_init; end
      REG_KI_INIT:        begin ki_init = val[19:0]; ki_now = ki_init; end
      REG_INTEGRAL_LIMIT: integ_lim = val[26:0];
      REG_DRIVE_LIMIT:    drive_lim = val[23:0];
      default: ;
    endcase
  endfunction

  // one item: random gap, offer, hold until taken, then predict
  task automatic send_item(logic [29:0] rmt, logic [29:0] loc, logic vld);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    remote_offset_ns <= rmt;
    local_offset_ns <= loc;
    local_offset_valid <= vld;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(pi_update(rmt, loc, vld));
    items_sent++;
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_write(idx, val);
    cfg_writes++;
  endtask

  // mostly near-aligned clocks so the schedule gets exercised, plus noise
  task automatic send_random_item();
    logic [29:0] rmt, loc;
    int sel;
    sel = $urandom_range(0, 99);
    rmt = 30'($urandom_range(0, 1000000000));
    if (sel < 55) begin
      loc = rmt + 30'($urandom_range(0, 400000)) - 30'd200000;
      if (sync_ns > 0 && loc >= sync_ns) loc = rmt;
    end else if (sel < 70) begin
      loc = 30'($urandom_range(0, 1000000000));
    end else if (sel < 85) begin
      rmt = 30'($urandom); loc = 30'($urandom);
    end else begin
      loc = 30'($urandom);
    end
    send_item(rmt, loc, sel < 92);
  endtask

  task automatic random_config();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = 2; 1: v = 1000000000; 2: v = 100000000;
      default: v = $urandom_range(1000, 1000000000);
    endcase
    cfg_write(REG_SYNC_INTERVAL, v);
    case ($urandom_range(0, 3))
      0: v = 1; 1: v = 1000000; default: v = $urandom_range(1, 20000);
    endcase
    cfg_write(REG_SAMPLES, v);
    cfg_write(REG_SAMPLE_TICKS, $urandom);
    cfg_write(REG_KP_INIT, $urandom_range(1, 1000000));
    cfg_write(REG_KI_INIT, $urandom_range(1, 1000000));
    cfg_write(REG_INTEGRAL_LIMIT, $urandom_range(0, 100000000));
    cfg_write(REG_DRIVE_LIMIT, $urandom_range(0, 10000000));
  endtask

  // field extremes, fold in both directions, smoothed error decay and a large error
  task automatic test_directed();
    send_item('0, '0, 1'b1);
    send_item('1, '0, 1'b1);
    send_item('0, '1, 1'b1);
    send_item('1, '1, 1'b0);
    send_item(30'd90000000, 30'd1000000, 1'b1);   // folds down
    send_item(30'd1000000, 30'd90000000, 1'b1);   // folds up
    send_item(30'd50000000, 30'd0, 1'b1);         // exactly half
    // zero error decays the smoothed error
    repeat (16) send_item(30'd12345, 30'd777, 1'b0);
    send_item(30'd500, 30'd0, 1'b1);
    send_item(30'd49000000, 30'd0, 1'b1);         // large error raises the smoothed error
    drain();
  endtask

  // register extremes, zero gains, zero samples, lowered limits
  task automatic test_register_extremes();
    cfg_write(REG_SAMPLES, 0);
    cfg_write(REG_KP_INIT, 0);
    cfg_write(REG_KI_INIT, 0);
    repeat (30) send_random_item();
    drain();
    cfg_write(REG_SYNC_INTERVAL, 32'h3FFFFFFF);
    cfg_write(REG_SAMPLES, 32'hFFFFF);
    cfg_write(REG_SAMPLE_TICKS, 32'hFFFFFFFF);
    cfg_write(REG_KP_INIT, 1);
    cfg_write(REG_KI_INIT, 1);
    cfg_write(REG_INTEGRAL_LIMIT, 32'h7FFFFFF);
    cfg_write(REG_DRIVE_LIMIT, 32'hFFFFFF);
    repeat (40) send_random_item();
    drain();
    // lowered limits clamp the stored integral at the next update
    cfg_write(REG_INTEGRAL_LIMIT, 0);
    cfg_write(REG_DRIVE_LIMIT, 0);
    cfg_write(REG_SYNC_INTERVAL, 0);
    cfg_write(REG_SAMPLE_TICKS, 0);
    repeat (20) send_random_item();
    drain();
    cfg_write(REG_SYNC_INTERVAL, 2);
    cfg_write(REG_SAMPLES, 1);
    cfg_write(REG_KP_INIT, 1000000);
    cfg_write(REG_KI_INIT, 1000000);
    cfg_write(REG_INTEGRAL_LIMIT, 100000000);
    cfg_write(REG_DRIVE_LIMIT, 10000000);
    repeat (30) send_random_item();
    drain();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 7; p++) begin
      random_config();
      no_idle = (p == 2);
      repeat (70) send_random_item();
      drain();
    end
    no_idle = 0;
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    no_idle = 1;
    hold_trig++;
    repeat (25) send_random_item();
    drain();
    no_idle = 0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
    fails++;
  endtask

  // receiver side: random stall per result, long hold on request, checking
  int wait_left = 0, hold_left = 0, hold_seen = 0, idle_cycles = 0;
  always @(posedge clk) begin
    sync_result_t want;
    if (!rst) begin
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("gain_scheduled_pi_clock_sync verification failed");
        $finish;
      end
      if (hold_trig != hold_seen) begin
        hold_seen = hold_trig;
        hold_left = LONG_HOLD;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("result %0d arrived with nothing outstanding", results_seen);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (ticks_per_sample !== want.ticks)
            report_mismatch("ticks_per_sample", ticks_per_sample, want.ticks);
          if (remainder_ns !== want.rem)
            report_mismatch("remainder_ns", remainder_ns, want.rem);
          if (drive_ns !== want.drive)
            report_mismatch("drive_ns", drive_ns, want.drive);
          if (gain_step !== want.step)
            report_mismatch("gain_step", gain_step, want.step);
        end
        results_seen++;
        wait_left = no_idle ? 0 : $urandom_range(0, 7);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      if (hold_left > 0) hold_left--;
      out_stall <= (hold_left > 0) || (wait_left > 0);
    end
  end

  initial begin
    model_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    test_random_phases();
    drain();
    $display("covered %0d items and %0d results over %0d register writes,",
             items_sent, results_seen, cfg_writes);
    $display("including gain schedule steps, folds, saturation and a long hold-off");
    if (fails == 0 && pending_results.size() == 0) begin
      $display("gain_scheduled_pi_clock_sync verification clean");
    end else begin
      if (pending_results.size() != 0)
        $display("%0d results never arrived", pending_results.size());
      $display("gain_scheduled_pi_clock_sync verification failed");
    end
    $finish;
  end

endmodule
